@@ rtl/sspc_pkg.sv @@
// Shared types and constants for the stepper step pulse controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package sspc_pkg;

    localparam int CMD_W      = 32;
    localparam int OP_W       = 3;
    localparam int ST_W       = 3;
    localparam int TRAVEL_W   = 31;
    localparam int TIMEOUT_W  = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_REL  = 3'd1;
    localparam logic [OP_W-1:0] OP_ABS  = 3'd2;
    localparam logic [OP_W-1:0] OP_HOME = 3'd3;
    localparam logic [OP_W-1:0] OP_ZERO = 3'd4;

    localparam logic [ST_W-1:0] ST_NONE      = 3'd0;
    localparam logic [ST_W-1:0] ST_DONE      = 3'd1;
    localparam logic [ST_W-1:0] ST_ENDSTOP   = 3'd2;
    localparam logic [ST_W-1:0] ST_LIMIT     = 3'd3;
    localparam logic [ST_W-1:0] ST_HOMED     = 3'd4;
    localparam logic [ST_W-1:0] ST_TIMEOUT   = 3'd5;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRAVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_FORWARD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVER_EN    = 2'd3;

    localparam logic [TRAVEL_W-1:0]  MAX_TRAVEL_RST   = 31'h7FFF_FFFF;
    localparam logic [TIMEOUT_W-1:0] HOME_TIMEOUT_RST = 25'd20000000;

    typedef struct packed {
        logic [TRAVEL_W-1:0]  max_travel;
        logic                 home_forward;
        logic [TIMEOUT_W-1:0] home_timeout;
        logic                 driver_enable;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/sspc_cfg_regs.sv @@
// Configuration register file for the stepper step pulse controller.
// Depends on sspc_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module sspc_cfg_regs
    import sspc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_travel    <= MAX_TRAVEL_RST;
            r_cfg.home_forward  <= 1'b1;
            r_cfg.home_timeout  <= HOME_TIMEOUT_RST;
            r_cfg.driver_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_TRAVEL:   r_cfg.max_travel    <= i_cfg_data[TRAVEL_W-1:0];
                CFG_HOME_FORWARD: r_cfg.home_forward  <= i_cfg_data[0];
                CFG_HOME_TIMEOUT: r_cfg.home_timeout  <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_DRIVER_EN:    r_cfg.driver_enable <= i_cfg_data[0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/stepper_step_pulse_controller.sv @@
// Stepper step/direction pulse generator with homing, top level.
// Depends on sspc_pkg and sspc_cfg_regs.
//
// Usage: every input beat is one microsecond tick carrying the endstop level
// and, while idle, an optional command (relative move, absolute move, home,
// zero position). Every input beat yields exactly one output beat with the
// step, direction and enable pin levels, the busy flag, the position and a
// status code for that tick.
// Both channels are valid/ready. An accepted beat is held in an input
// register; when the result register is free, the motion state is updated
// and the result register loaded. One beat per cycle is sustained while the
// receiver takes every result; the rate is set by the single state-update
// pass between the input and result registers. When the receiver stalls,
// the result register holds and the input register fills; input ready then
// follows output ready in the same cycle. Configuration writes take effect
// at the next edge; the user must make them while idle; the block does not
// enforce it. Synchronous reset clears position, motion state and both valid
// flags and loads the configuration reset values; no sweep follows reset.
`default_nettype none

module stepper_step_pulse_controller
    import sspc_pkg::*;
#(
    parameter int POSITION_WIDTH    = 32,
    parameter int HALF_PERIOD_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_endstop_pressed,
    input  wire logic [OP_W-1:0]              i_op,
    input  wire logic signed [CMD_W-1:0]      i_cmd_steps,
    input  wire logic                         i_direction,
    input  wire logic [HALF_PERIOD_WIDTH-1:0] i_half_period_us,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_step_out,
    output logic                              o_dir_out,
    output logic                              o_enable_n,
    output logic                              o_busy_res,
    output logic signed [POSITION_WIDTH-1:0]  o_position,
    output logic [ST_W-1:0]                   o_status
);

    localparam int PW  = POSITION_WIDTH;
    localparam int HPW = HALF_PERIOD_WIDTH;
    localparam int DW  = ((PW > CMD_W) ? PW : CMD_W) + 1;
    localparam int AW  = ((PW + 1) > TRAVEL_W + 1) ? (PW + 1) : (TRAVEL_W + 1);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_MOVE,
        MODE_HOME
    } t_mode;

    t_cfg cfg;

    sspc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register
    logic                     r_in_valid;
    logic                     r_es;
    logic [OP_W-1:0]          r_op;
    logic signed [CMD_W-1:0]  r_cmd;
    logic                     r_dir;
    logic [HPW-1:0]           r_hp;

    // motion state
    logic [PW-1:0]            r_pos,     n_pos;
    logic [DW-1:0]            r_sl,      n_sl;
    logic [HPW-1:0]           r_ptimer,  n_ptimer;
    logic                     r_phigh,   n_phigh;
    t_mode                    r_mode,    n_mode;
    logic                     r_fwd,     n_fwd;
    logic [HPW-1:0]           r_lhp,     n_lhp;
    logic [TIMEOUT_W-1:0]     r_elapsed, n_elapsed;

    // result register
    logic                     r_out_valid;
    logic                     r_step, r_dir_o, r_en_n, r_busy;
    logic [PW-1:0]            r_pos_o;
    logic [ST_W-1:0]          r_st;

    logic                     adv;
    logic                     do_begin;
    logic [ST_W-1:0]          n_st;
    logic [HPW-1:0]           limit;
    logic signed [DW-1:0]     delta;
    logic [PW-1:0]            pos_step;
    logic signed [AW-1:0]     pos_x;
    logic [AW-1:0]            pos_abs;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    assign limit    = (r_lhp == '0) ? HPW'(1) : r_lhp;
    assign delta    = DW'(r_cmd) - DW'($signed(r_pos));
    assign pos_step = r_fwd ? r_pos + 1'b1 : r_pos - 1'b1;
    assign pos_x    = AW'($signed(pos_step));
    assign pos_abs  = pos_x[AW-1] ? AW'(-pos_x) : AW'(pos_x);

    always_comb begin
        n_pos     = r_pos;
        n_sl      = r_sl;
        n_ptimer  = r_ptimer;
        n_phigh   = r_phigh;
        n_mode    = r_mode;
        n_fwd     = r_fwd;
        n_lhp     = r_lhp;
        n_elapsed = r_elapsed;
        n_st      = ST_NONE;
        do_begin  = 1'b0;

        if (r_mode != MODE_IDLE) begin
            if (r_mode == MODE_HOME && r_elapsed != '1) begin
                n_elapsed = r_elapsed + 1'b1;
            end
            n_ptimer = r_ptimer + 1'b1;
            if (n_ptimer >= limit) begin
                if (r_phigh) begin
                    n_phigh  = 1'b0;
                    n_ptimer = '0;
                end else begin
                    n_pos = pos_step;
                    n_sl  = r_sl - 1'b1;
                    if (r_mode == MODE_MOVE && pos_abs > AW'(cfg.max_travel)) begin
                        n_mode = MODE_IDLE;
                        n_st   = ST_LIMIT;
                    end else if (n_sl == '0) begin
                        n_st   = (r_mode == MODE_MOVE) ? ST_DONE : ST_EXHAUSTED;
                        n_mode = MODE_IDLE;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
            end
        end else begin
            unique case (r_op)
                OP_REL: begin
                    if (r_cmd > 0) begin
                        n_mode    = MODE_MOVE;
                        n_fwd     = r_dir;
                        n_sl      = DW'(unsigned'(r_cmd));
                        n_lhp     = r_hp;
                        n_elapsed = '0;
                        do_begin  = 1'b1;
                    end
                end
                OP_ABS: begin
                    if (delta != '0) begin
                        n_mode    = MODE_MOVE;
                        n_fwd     = !delta[DW-1];
                        n_sl      = delta[DW-1] ? DW'(-delta) : DW'(delta);
                        n_lhp     = r_hp;
                        n_elapsed = '0;
                        do_begin  = 1'b1;
                    end
                end
                OP_HOME: begin
                    n_fwd = cfg.home_forward;
                    if (r_cmd > 0) begin
                        n_mode    = MODE_HOME;
                        n_sl      = DW'(unsigned'(r_cmd));
                        n_lhp     = r_hp;
                        n_elapsed = '0;
                        do_begin  = 1'b1;
                    end else begin
                        n_st = ST_EXHAUSTED;
                    end
                end
                OP_ZERO: begin
                    n_pos = '0;
                end
                default: begin
                end
            endcase
        end

        // start of a step: endstop and timeout checks
        if (do_begin) begin
            if (r_es) begin
                if (n_mode == MODE_HOME) begin
                    n_pos = '0;
                    n_st  = ST_HOMED;
                end else begin
                    n_st  = ST_ENDSTOP;
                end
                n_mode = MODE_IDLE;
            end else if (n_mode == MODE_HOME && n_elapsed > cfg.home_timeout) begin
                n_mode = MODE_IDLE;
                n_st   = ST_TIMEOUT;
            end else begin
                n_phigh  = 1'b1;
                n_ptimer = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_sl        <= '0;
            r_ptimer    <= '0;
            r_phigh     <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_fwd       <= 1'b0;
            r_lhp       <= '0;
            r_elapsed   <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
                r_es       <= i_endstop_pressed;
                r_op       <= i_op;
                r_cmd      <= i_cmd_steps;
                r_dir      <= i_direction;
                r_hp       <= i_half_period_us;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end

            if (adv) begin
                r_pos       <= n_pos;
                r_sl        <= n_sl;
                r_ptimer    <= n_ptimer;
                r_phigh     <= n_phigh;
                r_mode      <= n_mode;
                r_fwd       <= n_fwd;
                r_lhp       <= n_lhp;
                r_elapsed   <= n_elapsed;
                r_out_valid <= 1'b1;
                r_step      <= n_phigh;
                r_dir_o     <= n_fwd;
                r_en_n      <= !cfg.driver_enable;
                r_busy      <= (n_mode != MODE_IDLE);
                r_pos_o     <= n_pos;
                r_st        <= n_st;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_step_out  = r_step;
    assign o_dir_out   = r_dir_o;
    assign o_enable_n  = r_en_n;
    assign o_busy_res  = r_busy;
    assign o_position  = $signed(r_pos_o);
    assign o_status    = r_st;

    a_stop_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_NONE |-> !o_busy_res)
        else $error("stop status reported while busy");

    a_homed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_HOMED |-> o_position == '0)
        else $error("homed without zero position");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_cmd) && $stable(r_op))
        else $error("pending input beat lost");

    a_idle_sl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_mode != MODE_IDLE && n_mode != MODE_IDLE |-> n_sl != '0)
        else $error("running with no steps left");

endmodule

`default_nettype wire

@@ tb/tb_stepper_step_pulse_controller.sv @@
// Self-checking testbench for the stepper step pulse controller.
// Depends on sspc_pkg and stepper_step_pulse_controller; a tick-level
// predictor checks every result beat against the pin levels it expects.
`timescale 1ns / 100ps

module tb_stepper_step_pulse_controller;
    import sspc_pkg::*;

    localparam int POS_W       = 32;
    localparam int HP_W        = 16;
    localparam int STALL_LIMIT = 4000;

    typedef enum logic [1:0] {RUN_IDLE, RUN_MOVE, RUN_HOME} t_run;

    typedef struct {
        logic                    es;
        logic [OP_W-1:0]         op;
        logic signed [CMD_W-1:0] cmd;
        logic                    dir;
        logic [HP_W-1:0]         hp;
    } t_tick;

    typedef struct {
        logic                    step;
        logic                    dir;
        logic                    en_n;
        logic                    busy;
        logic signed [POS_W-1:0] pos;
        logic [ST_W-1:0]         st;
    } t_pins;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_MAX_TRAVEL;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    in_es = 1'b0;
    logic [OP_W-1:0]         in_op = OP_NONE;
    logic signed [CMD_W-1:0] in_cmd = '0;
    logic                    in_dir = 1'b0;
    logic [HP_W-1:0]         in_hp = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b1;
    logic                    step_out, dir_out, enable_n, busy_res;
    logic signed [POS_W-1:0] position;
    logic [ST_W-1:0]         status;

    stepper_step_pulse_controller #(
        .POSITION_WIDTH   (POS_W),
        .HALF_PERIOD_WIDTH(HP_W)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_endstop_pressed(in_es),
        .i_op             (in_op),
        .i_cmd_steps      (in_cmd),
        .i_direction      (in_dir),
        .i_half_period_us (in_hp),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_step_out       (step_out),
        .o_dir_out        (dir_out),
        .o_enable_n       (enable_n),
        .o_busy_res       (busy_res),
        .o_position       (position),
        .o_status         (status)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // predictor state and register copies
    logic [TRAVEL_W-1:0]  cfg_travel   = MAX_TRAVEL_RST;
    logic                 cfg_home_fwd = 1'b1;
    logic [TIMEOUT_W-1:0] cfg_timeout  = HOME_TIMEOUT_RST;
    logic                 cfg_drv_en   = 1'b0;

    logic [POS_W-1:0]     motor_pos  = '0;
    longint               steps_to_go = 0;
    int                   phase_cnt  = 0;
    logic                 pulse_on   = 1'b0;
    t_run                 motion     = RUN_IDLE;
    logic                 run_fwd    = 1'b0;
    logic [HP_W-1:0]      hp_latched = '0;
    logic [TIMEOUT_W-1:0] home_ticks = '0;

    t_tick  pending_ticks[$];
    t_pins  pin_levels_q[$];
    int     queued_cnt   = 0;
    int     accepted_cnt = 0;
    int     checked_cnt  = 0;
    int     err_cnt      = 0;
    int     settings_cnt = 1;
    int     status_hits[7];
    int unsigned cyc = 0;
    int     stall_cnt = 0;

    function automatic void start_pulse(input logic es, inout logic [ST_W-1:0] st);
        if (motion == RUN_MOVE) begin
            if (es) begin
                motion = RUN_IDLE;
                st = ST_ENDSTOP;
                return;
            end
        end else begin
            if (es) begin
                motor_pos = '0;
                motion = RUN_IDLE;
                st = ST_HOMED;
                return;
            end
            if (home_ticks > cfg_timeout) begin
                motion = RUN_IDLE;
                st = ST_TIMEOUT;
                return;
            end
        end
        pulse_on = 1'b1;
        phase_cnt = 0;
    endfunction

    function automatic void advance_run(input logic es, inout logic [ST_W-1:0] st);
        int     limit;
        longint p;
        limit = (hp_latched == 0) ? 1 : int'(hp_latched);
        if (motion == RUN_HOME && home_ticks != '1)
            home_ticks = home_ticks + 1'b1;
        phase_cnt++;
        if (phase_cnt < limit)
            return;
        if (pulse_on) begin
            pulse_on = 1'b0;
            phase_cnt = 0;
            return;
        end
        motor_pos = run_fwd ? motor_pos + 1'b1 : motor_pos - 1'b1;
        steps_to_go--;
        if (motion == RUN_MOVE) begin
            p = longint'($signed(motor_pos));
            if (p < 0)
                p = -p;
            if (p > longint'(cfg_travel)) begin
                motion = RUN_IDLE;
                st = ST_LIMIT;
                return;
            end
        end
        if (steps_to_go == 0) begin
            st = (motion == RUN_MOVE) ? ST_DONE : ST_EXHAUSTED;
            motion = RUN_IDLE;
            return;
        end
        start_pulse(es, st);
    endfunction

    function automatic void launch(input t_run mode, input logic fwd, input longint cnt,
                                   input logic [HP_W-1:0] hp, input logic es,
                                   inout logic [ST_W-1:0] st);
        motion = mode;
        run_fwd = fwd;
        steps_to_go = cnt;
        hp_latched = hp;
        home_ticks = '0;
        start_pulse(es, st);
    endfunction

    function automatic t_pins motor_tick(t_tick t);
        t_pins           r;
        logic [ST_W-1:0] st;
        longint          delta;
        st = ST_NONE;
        if (motion != RUN_IDLE) begin
            advance_run(t.es, st);
        end else begin
            case (t.op)
                OP_REL: begin
                    if (t.cmd > 0)
                        launch(RUN_MOVE, t.dir, longint'(t.cmd), t.hp, t.es, st);
                end
                OP_ABS: begin
                    delta = longint'(t.cmd) - longint'($signed(motor_pos));
                    if (delta != 0)
                        launch(RUN_MOVE, delta > 0, (delta > 0) ? delta : -delta,
                               t.hp, t.es, st);
                end
                OP_HOME: begin
                    run_fwd = cfg_home_fwd;
                    if (t.cmd > 0)
                        launch(RUN_HOME, cfg_home_fwd, longint'(t.cmd), t.hp, t.es, st);
                    else
                        st = ST_EXHAUSTED;
                end
                OP_ZERO: motor_pos = '0;
                default: ;
            endcase
        end
        r.step = pulse_on;
        r.dir  = run_fwd;
        r.en_n = ~cfg_drv_en;
        r.busy = (motion != RUN_IDLE);
        r.pos  = motor_pos;
        r.st   = st;
        return r;
    endfunction

    function automatic bit take_gap();
        if ((cyc % 3000) < 700)
            return 1'b0;
        return $urandom_range(99) < 20;
    endfunction

    function automatic void compare_pin(string what, longint want, longint got);
        if (want != got) begin
            err_cnt++;
            if (err_cnt <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
    end

    // driver: feed ticks from the pending queue, hold each until accepted
    always @(posedge clk) begin
        t_tick t;
        t_tick cur;
        bit    load;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            load = !in_valid;
            if (in_valid && in_ready) begin
                cur.es = in_es;
                cur.op = in_op;
                cur.cmd = in_cmd;
                cur.dir = in_dir;
                cur.hp = in_hp;
                pin_levels_q.push_back(motor_tick(cur));
                accepted_cnt++;
                load = 1'b1;
            end
            if (load) begin
                if (pending_ticks.size() != 0 && !take_gap()) begin
                    t = pending_ticks.pop_front();
                    in_es <= t.es;
                    in_op <= t.op;
                    in_cmd <= t.cmd;
                    in_dir <= t.dir;
                    in_hp <= t.hp;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat against the oldest expected pin levels
    always @(posedge clk) begin
        t_pins w;
        out_ready <= !take_gap();
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (pin_levels_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 40)
                    $display("%0t: result beat with nothing expected, actual position %0h",
                             $time, position);
            end else begin
                w = pin_levels_q.pop_front();
                compare_pin("step_out", longint'(w.step), longint'(step_out));
                compare_pin("dir_out", longint'(w.dir), longint'(dir_out));
                compare_pin("enable_n", longint'(w.en_n), longint'(enable_n));
                compare_pin("busy_res", longint'(w.busy), longint'(busy_res));
                compare_pin("position", longint'(w.pos), longint'(position));
                compare_pin("status", longint'(w.st), longint'(status));
                if (w.st <= ST_EXHAUSTED)
                    status_hits[w.st]++;
                checked_cnt++;
            end
        end
    end

    function automatic void queue_tick(logic es, logic [OP_W-1:0] op,
                                       logic signed [CMD_W-1:0] cmd, logic dir,
                                       logic [HP_W-1:0] hp);
        t_tick t;
        t.es = es;
        t.op = op;
        t.cmd = cmd;
        t.dir = dir;
        t.hp = hp;
        pending_ticks.push_back(t);
        queued_cnt++;
    endfunction

    function automatic void queue_wait(int n, logic es);
        for (int i = 0; i < n; i++)
            queue_tick(es, OP_NONE, $urandom, 1'($urandom_range(1)), HP_W'($urandom));
    endfunction

    // one tick of background traffic, mostly plain ticks and ignored commands
    function automatic void queue_filler(logic es);
        int r;
        r = $urandom_range(99);
        if (r < 80)
            queue_tick(es, OP_NONE, $urandom, 1'($urandom_range(1)), HP_W'($urandom));
        else if (r < 88)
            queue_tick(es, OP_W'($urandom_range(5, 7)), $urandom, 1'($urandom_range(1)),
                       HP_W'($urandom));
        else if (r < 93)
            queue_tick(es, OP_REL, $urandom | 32'h8000_0000, 1'($urandom_range(1)),
                       HP_W'($urandom));
        else if (r < 97)
            queue_tick(es, OP_REL, $urandom_range(1, 3), 1'($urandom_range(1)),
                       HP_W'($urandom_range(1)));
        else
            queue_tick(1'b1, OP_ABS, $urandom, 1'($urandom_range(1)), HP_W'($urandom));
    endfunction

    function automatic void queue_sequence();
        int                      r;
        int                      hp;
        int                      span;
        int                      press_at;
        int                      press_len;
        logic signed [CMD_W-1:0] cnt;
        r = $urandom_range(99);
        hp = $urandom_range(3);
        span = 2 * ((hp == 0) ? 1 : hp);
        if (r < 28) begin
            cnt = $urandom_range(1, 6);
            if ($urandom_range(9) == 0)
                cnt = $urandom_range(1) ? '0 : ($urandom | 32'h8000_0000);
            queue_tick($urandom_range(99) < 5, OP_REL, cnt, 1'($urandom_range(1)),
                       HP_W'(hp));
            if (cnt > 0)
                for (int i = 0; i < span * cnt + $urandom_range(3); i++)
                    queue_filler($urandom_range(99) < 3);
        end else if (r < 50) begin
            queue_tick($urandom_range(99) < 5, OP_ABS, $urandom_range(16) - 8,
                       1'($urandom_range(1)), HP_W'(hp));
            for (int i = 0; i < span * 8 + $urandom_range(3); i++)
                queue_filler($urandom_range(99) < 3);
        end else if (r < 72) begin
            hp = $urandom_range(2);
            span = 2 * ((hp == 0) ? 1 : hp);
            cnt = $urandom_range(1, 12);
            span = span * cnt + 2;
            press_at = ($urandom_range(9) < 6) ? $urandom_range(span) : span + 100;
            press_len = $urandom_range(1, 5);
            queue_tick(press_at == 0, OP_HOME, cnt, 1'($urandom_range(1)), HP_W'(hp));
            for (int i = 1; i <= span; i++)
                queue_filler(i >= press_at && i < press_at + press_len);
        end else if (r < 78) begin
            queue_tick(1'($urandom_range(1)), OP_HOME,
                       $urandom_range(1) ? '0 : ($urandom | 32'h8000_0000),
                       1'($urandom_range(1)), HP_W'($urandom));
        end else if (r < 84) begin
            queue_tick(1'($urandom_range(1)), OP_ZERO, $urandom, 1'($urandom_range(1)),
                       HP_W'($urandom));
        end else if (r < 92) begin
            queue_filler(1'($urandom_range(1)));
        end else begin
            queue_tick(1'b1, OP_ABS, $urandom, 1'($urandom_range(1)), HP_W'($urandom));
        end
    endfunction

    task automatic fill_random(int n);
        int start;
        start = queued_cnt;
        while (queued_cnt - start < n)
            queue_sequence();
    endtask

    task automatic settle();
        while (accepted_cnt != queued_cnt || pin_levels_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_settings(logic [TRAVEL_W-1:0] trv, logic hf,
                                  logic [TIMEOUT_W-1:0] tmo, logic de);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAX_TRAVEL;
        cfg_data <= CFG_DATA_W'(trv);
        cfg_travel = trv;
        @(posedge clk);
        cfg_index <= CFG_HOME_FORWARD;
        cfg_data <= CFG_DATA_W'(hf);
        cfg_home_fwd = hf;
        @(posedge clk);
        cfg_index <= CFG_HOME_TIMEOUT;
        cfg_data <= CFG_DATA_W'(tmo);
        cfg_timeout = tmo;
        @(posedge clk);
        cfg_index <= CFG_DRIVER_EN;
        cfg_data <= CFG_DATA_W'(de);
        cfg_drv_en = de;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    initial begin
        wait (stall_cnt >= STALL_LIMIT);
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("[stepper_step_pulse_controller] ERROR");
        $finish;
    end

    initial begin
        logic [TRAVEL_W-1:0]  trv;
        logic [TIMEOUT_W-1:0] tmo;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes, every op, ignored and degenerate commands
        queue_tick(1'b0, OP_NONE, '0, 1'b0, '0);
        queue_tick(1'b1, OP_ZERO, '1, 1'b1, '1);
        queue_tick(1'b0, OP_REL, '0, 1'b1, 16'd1);
        queue_tick(1'b0, OP_REL, 32'sh8000_0000, 1'b1, 16'd1);
        queue_tick(1'b0, OP_REL, 32'sd3, 1'b1, '0);
        queue_wait(8, 1'b0);
        queue_tick(1'b0, OP_REL, 32'sd2, 1'b0, 16'd2);
        queue_wait(10, 1'b0);
        queue_tick(1'b0, OP_ABS, 32'sd1, 1'b1, 16'd1);
        queue_tick(1'b0, OP_ABS, -32'sd2, 1'b0, 16'd1);
        queue_tick(1'b0, OP_REL, 32'sd1, 1'b0, '0);
        queue_tick(1'b0, OP_ABS, '0, 1'b1, '0);
        queue_tick(1'b1, OP_HOME, '1, 1'b1, '1);
        queue_tick(1'b0, OP_ZERO, '0, 1'b0, '0);
        queue_wait(12, 1'b0);
        queue_tick(1'b1, OP_REL, 32'sh7FFF_FFFF, 1'b1, '1);
        queue_tick(1'b0, OP_REL, 32'sd4, 1'b1, 16'd1);
        queue_wait(3, 1'b0);
        queue_wait(4, 1'b1);
        queue_wait(6, 1'b0);
        queue_tick(1'b1, OP_ABS, 32'sh7FFF_FFFF, 1'b1, '0);
        queue_tick(1'b1, OP_ABS, 32'sh8000_0000, 1'b0, '1);
        queue_tick(1'b0, OP_HOME, '0, 1'b0, '0);
        queue_tick(1'b0, OP_HOME, -32'sd5, 1'b0, '0);
        queue_tick(1'b0, OP_HOME, 32'sd5, 1'b0, '0);
        queue_wait(3, 1'b0);
        queue_wait(3, 1'b1);
        queue_tick(1'b0, OP_HOME, 32'sd3, 1'b0, '0);
        queue_wait(8, 1'b0);
        queue_tick(1'b1, OP_HOME, 32'sd7, 1'b0, 16'd2);
        queue_tick(1'b0, 3'd5, '1, 1'b1, '1);
        queue_tick(1'b0, 3'd6, '0, 1'b0, '0);
        queue_tick(1'b0, 3'd7, '1, 1'b1, '1);
        queue_tick(1'b0, OP_REL, 32'sd3, 1'b1, 16'd1);
        queue_tick(1'b0, OP_REL, 32'sd5, 1'b0, '0);
        queue_tick(1'b0, OP_ABS, -32'sd9, 1'b0, '0);
        queue_tick(1'b0, OP_HOME, 32'sd4, 1'b0, '0);
        queue_tick(1'b0, OP_ZERO, '0, 1'b0, '0);
        queue_wait(10, 1'b0);
        fill_random(30);
        settle();

        // zero travel and zero timeout: limit stop and home timeout
        write_settings('0, 1'b0, '0, 1'b1);
        queue_tick(1'b0, OP_REL, 32'sd2, 1'b1, '0);
        queue_wait(4, 1'b0);
        queue_tick(1'b0, OP_HOME, 32'sd5, 1'b1, '0);
        queue_wait(6, 1'b0);
        queue_tick(1'b0, OP_ABS, -32'sd3, 1'b0, '0);
        queue_wait(4, 1'b0);
        fill_random(20);
        settle();

        write_settings('1, 1'b1, '1, 1'b0);
        fill_random(20);
        settle();

        write_settings(31'd5, 1'b1, 25'd30, 1'b1);
        fill_random(20);
        settle();

        write_settings(31'd3, 1'b0, 25'd12, 1'b0);
        fill_random(20);
        settle();

        for (int ph = 0; ph < 3; ph++) begin
            trv = ($urandom_range(2) == 0) ? MAX_TRAVEL_RST : TRAVEL_W'($urandom_range(8));
            tmo = ($urandom_range(2) == 0) ? HOME_TIMEOUT_RST : TIMEOUT_W'($urandom_range(40));
            write_settings(trv, 1'($urandom_range(1)), tmo, 1'($urandom_range(1)));
            fill_random(20);
            settle();
        end

        $display("ran %0d ticks over %0d register settings, %0d result beats checked",
                 accepted_cnt, settings_cnt, checked_cnt);
        $display("stops seen: done %0d, endstop %0d, limit %0d, homed %0d, timeout %0d, exhausted %0d",
                 status_hits[ST_DONE], status_hits[ST_ENDSTOP], status_hits[ST_LIMIT],
                 status_hits[ST_HOMED], status_hits[ST_TIMEOUT], status_hits[ST_EXHAUSTED]);
        if (err_cnt == 0 && pin_levels_q.size() == 0) begin
            $display("[stepper_step_pulse_controller] OK");
        end else begin
            $display("[stepper_step_pulse_controller] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/sspc_pkg.sv
rtl/sspc_cfg_regs.sv
rtl/stepper_step_pulse_controller.sv
tb/tb_stepper_step_pulse_controller.sv
